[sv/tss_pkg.sv]
`timescale 1ns / 1ps

package tss_pkg;

  // Series length and the fixed formats of the ports.
  localparam int unsigned MAX_TERMS = 20;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CNT_W-1:0] TERM_COUNT_RESET = CNT_W'(20);

  // Binary points: the angle is Q.28, products are Q.32, terms and sum are Q.40.
  localparam int unsigned IN_FRAC    = 28;
  localparam int unsigned Q_SHIFT    = 32;
  localparam int unsigned SUM_FRAC   = 40;
  localparam int unsigned OUT_FRAC   = 30;
  localparam int unsigned SQ_SHIFT   = 2 * IN_FRAC - Q_SHIFT;
  localparam int unsigned TERM_SHIFT = SUM_FRAC - IN_FRAC;
  localparam int unsigned RND_SHIFT  = SUM_FRAC - OUT_FRAC;

  // Internal widths: an angle of magnitude 8 gives x*x = 2^38, a ratio below 2^36,
  // terms below 2^49 and a sum well inside 54 signed bits.
  localparam int unsigned MAG_W     = DATA_W;
  localparam int unsigned XSQ_W     = 39;
  localparam int unsigned RECIP_W   = 30;
  localparam int unsigned RATIO_W   = 36;
  localparam int unsigned TERM_W    = 49;
  localparam int unsigned SUM_W     = 54;
  localparam int unsigned XSQ_LO_W  = 20;
  localparam int unsigned TERM_LO_W = 25;

  // Saturation and rounding constants.
  localparam logic signed [SUM_W-1:0]  SUM_ONE  = SUM_W'(64'd1 << SUM_FRAC);
  localparam logic signed [SUM_W-1:0]  RND_HALF = SUM_W'(64'd1 << (RND_SHIFT - 1));
  localparam logic signed [DATA_W-1:0] OUT_POS  = DATA_W'(64'd1 << OUT_FRAC);
  localparam logic signed [DATA_W-1:0] OUT_NEG  = -OUT_POS;

  // Reciprocal ROM: round(2^32 / ((2a+1)(2a))) for term a, entry zero unused.
  localparam logic [RECIP_W-1:0] RECIP_ROM [MAX_TERMS] = '{
    30'd0,        30'd715827883, 30'd214748365, 30'd102261126, 30'd59652324,
    30'd39045157, 30'd27531842,  30'd20452225,  30'd15790321,  30'd12558384,
    30'd10226113, 30'd8488078,   30'd7158279,   30'd6118187,   30'd5289369,
    30'd4618244,  30'd4067204,   30'd3609216,   30'd3224450,   30'd2898089
  };

  // Everything an item carries down the term pipeline.
  typedef struct packed {
    logic                    neg;
    logic [CNT_W-1:0]        n;
    logic [XSQ_W-1:0]        xsq;
    logic [TERM_W-1:0]       term;
    logic signed [SUM_W-1:0] sum;
  } tss_token_t;

  // Adds term k with its alternating sign when k is inside the configured length.
  function automatic logic signed [SUM_W-1:0] tss_accumulate(
    input logic signed [SUM_W-1:0] sum,
    input logic [TERM_W-1:0]       term,
    input logic                    neg,
    input logic [IDX_W-1:0]        k,
    input logic [CNT_W-1:0]        n
  );
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] r;
    t = $signed(SUM_W'(term));
    r = sum;
    if (CNT_W'(k) < n) begin
      if (neg ^ k[0]) begin
        r = sum - t;
      end else begin
        r = sum + t;
      end
    end
    return r;
  endfunction

endpackage

[sv/taylor_series_sine.sv]
// Throughput: one angle per cycle while the result is not stalled; each series term after
// the first owns a stage whose two multiplications are split into partial products.
// Reset clears every valid bit and sets term_count to 20; a stalled result holds
// the whole pipeline.
`timescale 1ns / 1ps

module taylor_series_sine import tss_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input angle: angle_rad [31:0], signed Q4.28.
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic signed [DATA_W-1:0] s_axis_tdata_i,
  // Result: sine_value [31:0], signed Q2.30.
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic signed [DATA_W-1:0] m_axis_tdata_o,
  // Configuration: term_count [4:0].
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_wdata_i
);

  logic                     adv;
  logic [CNT_W-1:0]         term_count_q;
  logic [CNT_W-1:0]         n_d, n_q;
  logic [MAG_W-1:0]         mag_d, mag_q;
  logic                     neg_q;
  logic                     in_valid_q;
  logic [2*MAG_W-1:0]       sq;
  tss_token_t               tok0_d, tok0_q;
  logic                     valid0_q;
  logic                     chain_valid [MAX_TERMS];
  tss_token_t               chain_tok   [MAX_TERMS];
  logic signed [SUM_W-1:0]  sumf_d, sumf_q;
  logic                     validf_q;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [DATA_W-1:0] sine_d, sine_q;
  logic                     out_valid_q;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TERM_COUNT_RESET;
    end else if (cfg_we_i) begin
      term_count_q <= cfg_wdata_i;
    end
  end

  // Input stage: clamp the term count and take the magnitude of the angle.
  always_comb begin
    if (term_count_q == '0) begin
      n_d = CNT_W'(1);
    end else if (term_count_q > CNT_W'(MAX_TERMS)) begin
      n_d = CNT_W'(MAX_TERMS);
    end else begin
      n_d = term_count_q;
    end
    mag_d = s_axis_tdata_i[DATA_W-1] ? MAG_W'(-s_axis_tdata_i) : MAG_W'(s_axis_tdata_i);
  end

  // Square stage: x*x in Q.32 and the first term in Q.40.
  always_comb begin
    sq          = (2*MAG_W)'(mag_q) * (2*MAG_W)'(mag_q);
    tok0_d.neg  = neg_q;
    tok0_d.n    = n_q;
    tok0_d.xsq  = sq[SQ_SHIFT +: XSQ_W];
    tok0_d.term = TERM_W'(mag_q) << TERM_SHIFT;
    tok0_d.sum  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      valid0_q   <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid_i;
      valid0_q   <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q  <= mag_d;
      neg_q  <= s_axis_tdata_i[DATA_W-1];
      n_q    <= n_d;
      tok0_q <= tok0_d;
    end
  end

  // Term pipeline: one stage per further series term.
  assign chain_valid[0] = valid0_q;
  assign chain_tok[0]   = tok0_q;

  for (genvar g = 1; g < MAX_TERMS; g++) begin : g_term
    tss_term_stage u_term_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .step_i  (IDX_W'(g)),
      .valid_i (chain_valid[g-1]),
      .tok_i   (chain_tok[g-1]),
      .valid_o (chain_valid[g]),
      .tok_o   (chain_tok[g])
    );
  end

  // Final stage: add the last term that the chain produced.
  assign sumf_d = tss_accumulate(chain_tok[MAX_TERMS-1].sum, chain_tok[MAX_TERMS-1].term,
                                 chain_tok[MAX_TERMS-1].neg, IDX_W'(MAX_TERMS - 1),
                                 chain_tok[MAX_TERMS-1].n);

  // Saturate to plus or minus one, otherwise round half up to Q2.30.
  always_comb begin
    rnd = (sumf_q + RND_HALF) >>> RND_SHIFT;
    if (sumf_q >= SUM_ONE) begin
      sine_d = OUT_POS;
    end else if (sumf_q <= -SUM_ONE) begin
      sine_d = OUT_NEG;
    end else begin
      sine_d = $signed(rnd[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      validf_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      validf_q    <= chain_valid[MAX_TERMS-1];
      out_valid_q <= validf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sumf_q <= sumf_d;
      sine_q <= sine_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = sine_q;

endmodule

[sv/tss_term_stage.sv]
`timescale 1ns / 1ps

module tss_term_stage import tss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [IDX_W-1:0] step_i,
  input  logic             valid_i,
  input  tss_token_t       tok_i,
  output logic             valid_o,
  output tss_token_t       tok_o
);

  localparam int unsigned PPR_LO_W = XSQ_LO_W + RECIP_W;
  localparam int unsigned PPR_HI_W = XSQ_W - XSQ_LO_W + RECIP_W;
  localparam int unsigned RPROD_W  = XSQ_W + RECIP_W;
  localparam int unsigned PPT_LO_W = TERM_LO_W + RATIO_W;
  localparam int unsigned PPT_HI_W = TERM_W - TERM_LO_W + RATIO_W;
  localparam int unsigned TPROD_W  = TERM_W + RATIO_W;

  logic [RECIP_W-1:0]  recip;
  logic [IDX_W-1:0]    prev;
  logic [3:0]          valid_q;
  tss_token_t          tok1_d, tok1_q, tok2_q, tok3_q, tok4_d, tok4_q;
  logic [PPR_LO_W-1:0] ppr_lo_d, ppr_lo_q;
  logic [PPR_HI_W-1:0] ppr_hi_d, ppr_hi_q;
  logic [RPROD_W-1:0]  rprod;
  logic [RATIO_W-1:0]  ratio_d, ratio_q;
  logic [PPT_LO_W-1:0] ppt_lo_d, ppt_lo_q;
  logic [PPT_HI_W-1:0] ppt_hi_d, ppt_hi_q;
  logic [TPROD_W-1:0]  tprod;

  // The step index is tied off per instance, so the ROM read folds to a constant.
  assign recip = RECIP_ROM[step_i];
  assign prev  = step_i - IDX_W'(1);

  // First step: fold the previous term into the sum and form x*x*recip partials.
  always_comb begin
    tok1_d     = tok_i;
    tok1_d.sum = tss_accumulate(tok_i.sum, tok_i.term, tok_i.neg, prev, tok_i.n);
    ppr_lo_d   = PPR_LO_W'(tok_i.xsq[XSQ_LO_W-1:0]) * PPR_LO_W'(recip);
    ppr_hi_d   = PPR_HI_W'(tok_i.xsq[XSQ_W-1:XSQ_LO_W]) * PPR_HI_W'(recip);
  end

  // Second step: combine the partials into the ratio for this term.
  always_comb begin
    rprod   = (RPROD_W'(ppr_hi_q) << XSQ_LO_W) + RPROD_W'(ppr_lo_q);
    ratio_d = rprod[Q_SHIFT +: RATIO_W];
  end

  // Third step: term times ratio as two partial products.
  always_comb begin
    ppt_lo_d = PPT_LO_W'(tok2_q.term[TERM_LO_W-1:0]) * PPT_LO_W'(ratio_q);
    ppt_hi_d = PPT_HI_W'(tok2_q.term[TERM_W-1:TERM_LO_W]) * PPT_HI_W'(ratio_q);
  end

  // Fourth step: the new term, still to be added by the next stage.
  always_comb begin
    tprod       = (TPROD_W'(ppt_hi_q) << TERM_LO_W) + TPROD_W'(ppt_lo_q);
    tok4_d      = tok3_q;
    tok4_d.term = tprod[Q_SHIFT +: TERM_W];
  end

  // Valid bits travel with the data and hold while the pipeline is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok1_q   <= tok1_d;
      ppr_lo_q <= ppr_lo_d;
      ppr_hi_q <= ppr_hi_d;
      tok2_q   <= tok1_q;
      ratio_q  <= ratio_d;
      tok3_q   <= tok2_q;
      ppt_lo_q <= ppt_lo_d;
      ppt_hi_q <= ppt_hi_d;
      tok4_q   <= tok4_d;
    end
  end

  assign valid_o = valid_q[3];
  assign tok_o   = tok4_q;

endmodule

[sv/tss_checker.sv]
`timescale 1ns / 1ps

module tss_checker import tss_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready_o,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic signed [DATA_W-1:0] m_axis_tdata_o
);

  // Every result lies within the saturation limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o <= OUT_POS) && (m_axis_tdata_o >= OUT_NEG))
    else $error("sine result outside plus or minus one");

  // A refused result stalls the input side as well.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while the result is stalled");

  // With no result waiting the block always takes a new angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input refused with an empty output register");

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or was withdrawn");

endmodule

bind taylor_series_sine tss_checker u_tss_checker (.*);

[test/tb_taylor_series_sine.sv]
`timescale 1ns / 1ps

module tb_taylor_series_sine;
  import tss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned IDLE_PERCENT = 29;

  // Handy angles in Q4.28.
  localparam logic [DATA_W-1:0] ONE_Q28     = 32'h1000_0000;
  localparam logic [DATA_W-1:0] HALF_PI_Q28 = 32'd421657428;
  localparam logic [DATA_W-1:0] PI_Q28      = 32'd843314857;
  localparam logic [DATA_W-1:0] MOST_POS    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MOST_NEG    = 32'h8000_0000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid_i;
  logic                     s_axis_tready_o;
  logic signed [DATA_W-1:0] s_axis_tdata_i;
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i;
  logic signed [DATA_W-1:0] m_axis_tdata_o;
  logic                     cfg_we_i;
  logic [CNT_W-1:0]         cfg_wdata_i;

  // Local copy of the term count and the sines still owed by the block.
  logic [CNT_W-1:0]  term_count_copy = TERM_COUNT_RESET;
  logic [DATA_W-1:0] pending_sines[$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  bit                steady = 1'b0;

  taylor_series_sine uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // floor(a * b / 2^32) on unsigned operands.
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[95:32];
  endfunction

  // Sine of a Q4.28 angle as the truncated series, saturated and rounded to Q2.30.
  function automatic logic [DATA_W-1:0] series_sine(input logic [DATA_W-1:0] angle,
                                                    input logic [CNT_W-1:0] count);
    logic               neg;
    logic [63:0]        mag;
    logic [63:0]        xsq;
    logic [63:0]        term;
    logic [63:0]        ratio;
    logic [63:0]        divisor;
    logic [63:0]        recip;
    logic signed [63:0] acc;
    logic signed [63:0] one;
    logic signed [63:0] rounded;
    int unsigned        n;
    int unsigned        k;
    neg = angle[DATA_W-1];
    mag = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
    xsq = (mag * mag) >> 24;
    n = 32'(count);
    if (n < 1) n = 1;
    if (n > MAX_TERMS) n = MAX_TERMS;
    term = mag << 12;
    acc = neg ? -$signed(term) : $signed(term);
    for (k = 1; k < n; k++) begin
      divisor = 64'((2 * k + 1) * (2 * k));
      recip = ((64'd1 << 32) + divisor / 2) / divisor;
      ratio = scaled_product(xsq, recip);
      term = scaled_product(term, ratio);
      if (neg ^ (k % 2 == 1)) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    one = 64'sd1 <<< 40;
    if (acc >= one) return 32'h4000_0000;
    if (acc <= -one) return 32'hC000_0000;
    rounded = (acc + 64'sd512) >>> 10;
    return rounded[DATA_W-1:0];
  endfunction

  // Angle mix: full range, within plus or minus pi, near zero, and the extremes.
  function automatic logic [DATA_W-1:0] random_angle();
    logic [DATA_W-1:0] a;
    case ($urandom_range(3))
      0: a = $urandom;
      1: a = $urandom_range(2 * PI_Q28) - PI_Q28;
      2: a = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: begin
        case ($urandom_range(4))
          0: a = MOST_POS;
          1: a = MOST_NEG;
          2: a = 32'h8000_0001;
          3: a = 32'hFFFF_FFFF;
          default: a = 32'd0;
        endcase
      end
    endcase
    return a;
  endfunction

  // Sends one angle; the valid stays high after the transfer for the next call.
  task automatic send_angle(input logic [DATA_W-1:0] angle);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i = $urandom;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = angle;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_sines.push_back(series_sine(angle, term_count_copy));
  endtask

  // Stops sending and waits for every owed sine.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_sines.size() != 0) @(posedge clk_i);
  endtask

  // Writes the term count while the pipeline is empty.
  task automatic write_term_count(input logic [CNT_W-1:0] count);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = count;
    @(posedge clk_i);
    term_count_copy = count;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_wdata_i = CNT_W'($urandom);
  endtask

  // Extreme and landmark angles at the reset term count.
  task automatic test_landmark_angles();
    logic [DATA_W-1:0] angles[$];
    angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, ONE_Q28, -ONE_Q28, HALF_PI_Q28, -HALF_PI_Q28,
               PI_Q28, -PI_Q28, 32'h4000_0000, MOST_POS, MOST_NEG, 32'h5555_5555,
               32'hAAAA_AAAA};
    foreach (angles[i]) send_angle(angles[i]);
  endtask

  // Zero terms behaves as one, and counts above the maximum saturate.
  task automatic test_term_count_limits();
    logic [CNT_W-1:0]  counts[$];
    logic [DATA_W-1:0] angles[$];
    counts = '{5'd0, 5'd1, 5'd31};
    angles = '{HALF_PI_Q28, MOST_NEG, 32'h7000_0000};
    foreach (counts[c]) begin
      write_term_count(counts[c]);
      foreach (angles[i]) send_angle(angles[i]);
    end
  endtask

  // Random angles across several term counts, the extremes among them.
  task automatic test_random_angles();
    logic [CNT_W-1:0] count;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: count = 5'd1;
        1: count = 5'd20;
        2: count = 5'd21;
        3: count = 5'd2;
        default: count = CNT_W'($urandom_range(31));
      endcase
      write_term_count(count);
      repeat (100) send_angle(random_angle());
    end
  endtask

  // A long run with no gaps on either side, then a full pause for the pipeline to empty.
  task automatic test_back_to_back();
    write_term_count(TERM_COUNT_RESET);
    steady = 1'b1;
    repeat (100) send_angle(random_angle());
    wait_drained();
    steady = 1'b0;
  endtask

  // Result side: random back-pressure, checked against the oldest owed sine.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  initial begin
    logic [DATA_W-1:0] want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_sines.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result transfer: %h", m_axis_tdata_o);
        end else begin
          want = pending_sines.pop_front();
          if (m_axis_tdata_o !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("sine_value mismatch: expected %h, got %h", want, m_axis_tdata_o);
          end
        end
      end
    end
  end

  // Guard against a hung pipeline.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Reset, the tests in turn, then the verdict.
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_landmark_angles();
    test_term_count_limits();
    test_random_angles();
    test_back_to_back();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_sines.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/tss_pkg.sv
sv/tss_term_stage.sv
sv/taylor_series_sine.sv
sv/tss_checker.sv
test/tb_taylor_series_sine.sv
